// ===== src/ptw_pkg.sv =====
// Shared types, constants and helpers for the page table walker.
package ptw_pkg;

  localparam int FRAME_COUNT       = 64;
  localparam int ENTRIES_PER_FRAME = 512;
  localparam int MEM_WORDS         = FRAME_COUNT * ENTRIES_PER_FRAME;
  localparam int FRAME_W           = $clog2(FRAME_COUNT);
  localparam int IDX_W             = $clog2(ENTRIES_PER_FRAME);
  localparam int ADDR_W            = $clog2(MEM_WORDS);
  localparam int LEVELS            = 4;
  localparam int LVL_W             = $clog2(LEVELS);

  // operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_EXEC  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // result status codes
  localparam logic [2:0] STS_OK          = 3'd0;
  localparam logic [2:0] STS_NOT_PRESENT = 3'd1;
  localparam logic [2:0] STS_USER_DENIED = 3'd2;
  localparam logic [2:0] STS_NO_EXEC     = 3'd3;
  localparam logic [2:0] STS_RANGE       = 3'd4;

  // entry bit positions
  localparam int PTE_PRESENT = 0;
  localparam int PTE_USER    = 2;
  localparam int PTE_NX      = 63;
  localparam int PTE_FRAME_LO = 12;
  localparam int PTE_FRAME_HI = 51;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_RESP
  } ptw_state_t;

  typedef struct packed {
    logic clr;        // write zero at clear pointer, advance
    logic accept;     // input transaction taken this cycle
    logic step;       // issue read for next level
    logic walk_load;  // capture walk result
    logic out_load;   // move result into output register
  } ptw_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic start_walk;
    logic walk_end;
    logic out_free;
  } ptw_sts_t;

  // 9-bit table index of a virtual address for a given level (0 = top)
  function automatic logic [IDX_W-1:0] va_index(input logic [47:0] va,
                                                input logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

// ===== src/ptw_ctrl.sv =====
// Walk sequencer: clear pass, accept, level stepping and result hand-off.
module ptw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ptw_pkg::ptw_sts_t sts,
  output ptw_pkg::ptw_cmd_t cmd
);

  ptw_pkg::ptw_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptw_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ptw_pkg::S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = ptw_pkg::S_IDLE;
      end
      ptw_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.start_walk ? ptw_pkg::S_WALK : ptw_pkg::S_RESP;
        end
      end
      ptw_pkg::S_WALK: begin
        if (sts.walk_end) begin
          cmd.walk_load = 1'b1;
          state_nxt     = ptw_pkg::S_RESP;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ptw_pkg::S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ptw_pkg::S_IDLE;
        end
      end
      default: state_nxt = ptw_pkg::S_CLEAR;
    endcase
  end

endmodule

// ===== src/ptw_dp.sv =====
// Page memory, walk registers, entry checks and output register.
module ptw_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ptw_pkg::ptw_cmd_t          cmd,
  output ptw_pkg::ptw_sts_t          sts,
  input  logic                       cfg_valid,
  input  logic [5:0]                 cfg_root_frame,
  input  logic [1:0]                 in_operation,
  input  logic [47:0]                in_vaddr,
  input  logic                       in_supervisor,
  input  logic [14:0]                in_word_index,
  input  logic [63:0]                in_word_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 out_status,
  output logic [1:0]                 out_fault_level,
  output logic [5:0]                 out_frame
);

  localparam int ADDR_W  = ptw_pkg::ADDR_W;
  localparam int FRAME_W = ptw_pkg::FRAME_W;
  localparam int LVL_W   = ptw_pkg::LVL_W;

  logic [63:0]         mem [ptw_pkg::MEM_WORDS];
  logic [63:0]         rd_data_r;
  logic [ADDR_W-1:0]   clr_cnt_r;
  logic [5:0]          root_frame_r;
  logic [1:0]          op_r;
  logic [47:0]         va_r;
  logic                sup_r;
  logic [LVL_W-1:0]    lvl_r;
  logic [2:0]          res_status_r;
  logic [1:0]          res_level_r;
  logic [5:0]          res_frame_r;
  logic                out_valid_r;
  logic [2:0]          out_status_r;
  logic [1:0]          out_level_r;
  logic [5:0]          out_frame_r;

  logic                we;
  logic [ADDR_W-1:0]   waddr;
  logic [63:0]         wdata;
  logic [ADDR_W-1:0]   raddr;
  logic                translate;
  logic                root_bad;
  logic [2:0]          acc_status;
  logic [FRAME_W-1:0]  next_frame;
  logic                next_bad;
  logic                is_last;
  logic [2:0]          walk_status;
  logic                walk_stop;

  // root register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_frame_r <= '0;
    end else if (cfg_valid) begin
      root_frame_r <= cfg_root_frame;
    end
  end

  // clear pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign sts.clr_last = (clr_cnt_r == ADDR_W'(ptw_pkg::MEM_WORDS - 1));

  // accept side decode
  assign translate  = (in_operation == ptw_pkg::OP_DATA) ||
                      (in_operation == ptw_pkg::OP_EXEC);
  assign root_bad   = 32'(root_frame_r) >= ptw_pkg::FRAME_COUNT;
  assign sts.start_walk = translate && !root_bad;
  assign acc_status = (translate && root_bad) ? ptw_pkg::STS_RANGE : ptw_pkg::STS_OK;

  // memory write port: clear sweep or table load
  always_comb begin
    if (cmd.clr) begin
      we    = 1'b1;
      waddr = clr_cnt_r;
      wdata = '0;
    end else begin
      we    = cmd.accept && (in_operation == ptw_pkg::OP_WRITE) &&
              (32'(in_word_index) < ptw_pkg::MEM_WORDS);
      waddr = in_word_index[ADDR_W-1:0];
      wdata = in_word_data;
    end
  end

  // entry checks on the word read for the current level
  assign next_frame = rd_data_r[ptw_pkg::PTE_FRAME_LO +: FRAME_W];
  assign next_bad   = |rd_data_r[ptw_pkg::PTE_FRAME_HI:ptw_pkg::PTE_FRAME_LO + FRAME_W];
  assign is_last    = (lvl_r == LVL_W'(ptw_pkg::LEVELS - 1));

  always_comb begin
    walk_stop   = 1'b1;
    walk_status = ptw_pkg::STS_OK;
    if (!rd_data_r[ptw_pkg::PTE_PRESENT]) begin
      walk_status = ptw_pkg::STS_NOT_PRESENT;
    end else if (op_r == ptw_pkg::OP_EXEC && rd_data_r[ptw_pkg::PTE_NX]) begin
      walk_status = ptw_pkg::STS_NO_EXEC;
    end else if (!sup_r && !rd_data_r[ptw_pkg::PTE_USER]) begin
      walk_status = ptw_pkg::STS_USER_DENIED;
    end else if (next_bad) begin
      walk_status = ptw_pkg::STS_RANGE;
    end else if (!is_last) begin
      walk_stop = 1'b0;
    end
  end

  assign sts.walk_end = walk_stop;

  // read address: level 0 at accept, following levels from the current entry
  always_comb begin
    if (cmd.accept) begin
      raddr = {root_frame_r[FRAME_W-1:0], ptw_pkg::va_index(in_vaddr, '0)};
    end else begin
      raddr = {next_frame, ptw_pkg::va_index(va_r, lvl_r + 1'b1)};
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.accept || cmd.step) rd_data_r <= mem[raddr];
  end

  // walk context
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_operation;
      va_r  <= in_vaddr;
      sup_r <= in_supervisor;
      lvl_r <= '0;
    end else if (cmd.step) begin
      lvl_r <= lvl_r + 1'b1;
    end
  end

  // staged result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_status_r <= acc_status;
      res_level_r  <= '0;
      res_frame_r  <= '0;
    end else if (cmd.walk_load) begin
      res_status_r <= walk_status;
      res_level_r  <= (walk_status == ptw_pkg::STS_OK) ? 2'd0 : lvl_r;
      res_frame_r  <= (walk_status == ptw_pkg::STS_OK) ? 6'(next_frame) : 6'd0;
    end
  end

  // output register
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_level_r  <= res_level_r;
      out_frame_r  <= res_frame_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_fault_level = out_level_r;
  assign out_frame       = out_frame_r;

endmodule

// ===== src/four_level_page_table_walker.sv =====
// Four-level page table walker: top level.
// After reset the block zeroes its 32768-word page memory, one word per cycle,
// and stalls its input until that sweep is done (root_frame writes are taken
// throughout). A table-word write or an unused operation goes from acceptance
// through the response state to the output register; a translation makes one
// read of the single synchronous page memory per walk level (four dependent
// reads, the next address coming from the entry just read) plus a result stage.
// A walk that faults early finishes sooner. One transaction is in flight at a
// time; the output register holds a finished result while the next input is
// accepted. cfg_ready is always high.
module four_level_page_table_walker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_root_frame,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [47:0] in_vaddr,
  input  logic        in_supervisor,
  input  logic [14:0] in_word_index,
  input  logic [63:0] in_word_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [1:0]  out_fault_level,
  output logic [5:0]  out_frame
);

  ptw_pkg::ptw_cmd_t cmd;
  ptw_pkg::ptw_sts_t sts;

  assign cfg_ready = 1'b1;

  ptw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptw_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_valid       (cfg_valid),
    .cfg_root_frame  (cfg_root_frame),
    .in_operation    (in_operation),
    .in_vaddr        (in_vaddr),
    .in_supervisor   (in_supervisor),
    .in_word_index   (in_word_index),
    .in_word_data    (in_word_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_fault_level (out_fault_level),
    .out_frame       (out_frame)
  );

endmodule

// ===== src/ptw_checker.sv =====
// Port-level checks for the page table walker, bound to the top level.
module ptw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [1:0]  out_fault_level,
  input logic [5:0]  out_frame
);

  // a held result does not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
    $stable(out_fault_level) && $stable(out_frame))
    else $error("result changed while stalled");

  // one transaction at a time: input stalls right after acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken back to back");

  a_ok_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ptw_pkg::STS_OK |-> out_fault_level == 2'd0)
    else $error("fault level set on ok result");

  a_fault_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ptw_pkg::STS_OK |-> out_frame == 6'd0)
    else $error("frame set on faulting result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ptw_pkg::STS_RANGE)
    else $error("undefined status code");

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_fault_level (out_fault_level),
  .out_frame       (out_frame)
);
